// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- src/pcx_rle_pkg.sv -----
`default_nettype none

package pcx_rle_pkg;

   // Run header marker and count mask.
   localparam logic [7:0] RUN_MARK = 8'hC0;
   localparam logic [7:0] RUN_MASK = 8'h3F;

   // Width used for comparisons against the line, width and height size registers.
   localparam int CFG_W = 17;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_BYTES_PER_LINE = 2'd0;
   localparam logic [1:0] CSR_PLANE_COUNT    = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd3;

   // One queued command: a byte and how many times to repeat it.
   typedef struct packed {
      logic [7:0] value;
      logic [5:0] count;
   } cmd_type;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0]      bytes_per_line;
      logic [2:0]       plane_count;
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] image_height;
   } csr_type;

   // Queue status seen by the producer and consumer sides.
   typedef struct packed {
      logic                      full;
      logic                      empty;
      logic [QUEUE_CNT_BITS-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- src/pcx_rle_front.sv -----
`default_nettype none

module pcx_rle_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [7:0]             req_in_byte,
   input  wire                    queue_full,
   output logic                   push_valid,
   output pcx_rle_pkg::cmd_type   push_cmd
);
   import pcx_rle_pkg::*;

   logic       awaiting_ff, awaiting_in;
   logic [5:0] run_ff, run_in;
   logic       accept;

   // A byte is taken whenever the queue has room for what it may produce.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the byte: run value, run header or literal.
   always_comb begin
      awaiting_in    = awaiting_ff;
      run_in         = run_ff;
      push_valid     = 1'b0;
      push_cmd.value = req_in_byte;
      push_cmd.count = 6'd1;
      if (accept) begin
         if (awaiting_ff) begin
            awaiting_in    = 1'b0;
            run_in         = 6'd0;
            push_cmd.count = run_ff;
            // A zero-length run consumes its value and produces nothing.
            push_valid     = (run_ff != 6'd0);
         end else if ((req_in_byte & RUN_MARK) == RUN_MARK) begin
            awaiting_in = 1'b1;
            run_in      = 6'((req_in_byte & RUN_MASK));
         end else begin
            push_valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         run_ff      <= 6'd0;
      end else begin
         awaiting_ff <= awaiting_in;
         run_ff      <= run_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcx_rle_queue.sv -----
`default_nettype none

module pcx_rle_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push_valid,
   input  wire  pcx_rle_pkg::cmd_type     push_cmd,
   input  wire                            pop,
   output pcx_rle_pkg::cmd_type           head_cmd,
   output pcx_rle_pkg::queue_status_type  status
);
   import pcx_rle_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcx_rle_back.sv -----
`default_nettype none

module pcx_rle_back #(
   parameter int COORD_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  pcx_rle_pkg::csr_type   csr,
   input  wire                          queue_empty,
   input  wire  pcx_rle_pkg::cmd_type   head_cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic [1:0]                   rsp_plane,
   output logic [COORD_BITS-1:0]        rsp_column,
   output logic [COORD_BITS-1:0]        rsp_row,
   output logic                         rsp_keep,
   output logic                         rsp_last_of_run,
   output logic                         rsp_end_of_image,
   output logic                         rsp_format_error
);
   import pcx_rle_pkg::*;

   localparam logic [CFG_W-1:0] COORD_LIMIT = CFG_W'(1) << COORD_BITS;

   // Command being expanded.
   logic                  cur_valid_ff, cur_valid_in;
   logic [7:0]            cur_value_ff, cur_value_in;
   logic [5:0]            cur_count_ff, cur_count_in;

   // Position in the image.
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [1:0]            plane_ff, plane_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  done_ff, done_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff;
   logic [1:0]            out_plane_ff;
   logic [COORD_BITS-1:0] out_column_ff;
   logic [COORD_BITS-1:0] out_row_ff;
   logic                  out_keep_ff, out_last_ff, out_eoi_ff, out_ferr_ff;

   logic [CFG_W-1:0]      bpl_ext, bpl_eff, hgt_eff;
   logic [2:0]            planes_eff;
   logic                  ferr;
   logic                  out_free, fire, finish, load;
   logic                  line_end, plane_last, row_last, eoi, keep;

   // Effective sizes: zero acts as one; clip at coordinate range, planes at four.
   always_comb begin
      bpl_ext = CFG_W'(csr.bytes_per_line);
      if (bpl_ext == '0) begin
         bpl_eff = CFG_W'(1);
      end else if (bpl_ext > COORD_LIMIT) begin
         bpl_eff = COORD_LIMIT;
      end else begin
         bpl_eff = bpl_ext;
      end
      if (csr.image_height == '0) begin
         hgt_eff = CFG_W'(1);
      end else if (csr.image_height > COORD_LIMIT) begin
         hgt_eff = COORD_LIMIT;
      end else begin
         hgt_eff = csr.image_height;
      end
      if (csr.plane_count == 3'd0) begin
         planes_eff = 3'd1;
      end else if (csr.plane_count > 3'd4) begin
         planes_eff = 3'd4;
      end else begin
         planes_eff = csr.plane_count;
      end
      ferr = !(csr.plane_count == 3'd1 || csr.plane_count == 3'd3 ||
               csr.plane_count == 3'd4);
   end

   // Position tests for the byte about to be emitted.
   assign line_end   = (CFG_W'(column_ff) + CFG_W'(1)) >= bpl_eff;
   assign plane_last = ({1'b0, plane_ff} + 3'd1) >= planes_eff;
   assign row_last   = (CFG_W'(row_ff) + CFG_W'(1)) >= hgt_eff;
   assign eoi        = line_end && plane_last && row_last;
   assign keep       = CFG_W'(column_ff) < csr.image_width;

   // Emit when a command is held and the output register can take a byte.
   assign out_free = !out_valid_ff || rsp_ready;
   assign fire     = cur_valid_ff && out_free && !done_ff;
   assign finish   = fire && (cur_count_ff == 6'd1 || line_end || eoi);
   assign load     = !queue_empty && (!cur_valid_ff || finish) && !done_ff;
   // Once the image is complete every queued command is dropped.
   assign pop      = load || (done_ff && !queue_empty);

   // Command register.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_value_in = cur_value_ff;
      cur_count_in = cur_count_ff;
      if (done_ff) begin
         cur_valid_in = 1'b0;
      end else if (load) begin
         cur_valid_in = 1'b1;
         cur_value_in = head_cmd.value;
         cur_count_in = head_cmd.count;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         cur_count_in = cur_count_ff - 6'd1;
      end
   end

   // Advance column, then plane, then row.
   always_comb begin
      column_in = column_ff;
      plane_in  = plane_ff;
      row_in    = row_ff;
      done_in   = done_ff;
      if (fire) begin
         if (eoi) begin
            done_in   = 1'b1;
            column_in = '0;
            plane_in  = '0;
            row_in    = '0;
         end else if (line_end) begin
            column_in = '0;
            if (plane_last) begin
               plane_in = '0;
               row_in   = row_ff + COORD_BITS'(1);
            end else begin
               plane_in = plane_ff + 2'd1;
            end
         end else begin
            column_in = column_ff + COORD_BITS'(1);
         end
      end
   end

   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         column_ff    <= '0;
         plane_ff     <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         column_ff    <= column_in;
         plane_ff     <= plane_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_value_ff <= cur_value_in;
      cur_count_ff <= cur_count_in;
      if (fire) begin
         out_byte_ff   <= cur_value_ff;
         out_plane_ff  <= plane_ff;
         out_column_ff <= column_ff;
         out_row_ff    <= row_ff;
         out_keep_ff   <= keep;
         out_last_ff   <= finish;
         out_eoi_ff    <= eoi;
         out_ferr_ff   <= ferr;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_plane        = out_plane_ff;
   assign rsp_column       = out_column_ff;
   assign rsp_row          = out_row_ff;
   assign rsp_keep         = out_keep_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_end_of_image = out_eoi_ff;
   assign rsp_format_error = out_ferr_ff;

endmodule

`default_nettype wire

// ----- src/pcx_rle_scanline_decoder.sv -----
// PCX 8-bit RLE scanline decoder.
// The req channel takes one compressed byte per transfer (req_valid/req_ready).
// The rsp channel delivers decoded bytes, each tagged with plane, column, row,
// a keep flag for columns below the image width, last_of_run, end_of_image
// and format_error. The csr port writes bytes_per_line, plane_count,
// image_width and image_height; write it only while the block is idle.
// A literal byte or run value enters a four-entry command queue; the back end
// expands each command at one result per cycle unless the receiver stalls, so
// literals sustain one byte per cycle in and out. A run is expanded through the
// single output register; a run header produces no output.
// Input bytes reach rsp_valid through the queue, command and output registers.
// When the receiver stalls, the output register holds its result, the back
// end stops expanding, the queue fills and req_ready drops once it is full.
// After the final byte of the last row all further input is taken and dropped
// until reset. Synchronous reset clears the position, the pending run header,
// the queue and the output; the size registers return to one.
`default_nettype none
`include "assert_macros.svh"

module pcx_rle_scanline_decoder #(
   parameter int COORD_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_plane,
   output logic [COORD_BITS-1:0] rsp_column,
   output logic [COORD_BITS-1:0] rsp_row,
   output logic                  rsp_keep,
   output logic                  rsp_last_of_run,
   output logic                  rsp_end_of_image,
   output logic                  rsp_format_error,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_index,
   input  wire  [16:0]           csr_wdata
);
   import pcx_rle_pkg::*;

   csr_type          csr_ff, csr_in;
   logic             push_valid;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             pop;
   queue_status_type q_status;

   // Configuration register writes.
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BYTES_PER_LINE: csr_in.bytes_per_line = csr_wdata[15:0];
            CSR_PLANE_COUNT:    csr_in.plane_count    = csr_wdata[2:0];
            CSR_IMAGE_WIDTH:    csr_in.image_width    = csr_wdata;
            CSR_IMAGE_HEIGHT:   csr_in.image_height   = csr_wdata;
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.bytes_per_line <= 16'd1;
         csr_ff.plane_count    <= 3'd1;
         csr_ff.image_width    <= CFG_W'(1);
         csr_ff.image_height   <= CFG_W'(1);
      end else begin
         csr_ff <= csr_in;
      end
   end

   pcx_rle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .queue_full  (q_status.full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   pcx_rle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .status     (q_status)
   );

   pcx_rle_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .queue_empty      (q_status.empty),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_plane        (rsp_plane),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_keep         (rsp_keep),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_image (rsp_end_of_image),
      .rsp_format_error (rsp_format_error)
   );

   // The queue never holds more than its depth.
   `ASSERT_NEVER(a_queue_bound, clock, reset, q_status.count > QUEUE_CNT_BITS'(QUEUE_DEPTH))
   // The final byte of the image always closes its run.
   `ASSERT_PROP(a_eoi_last, clock, reset, rsp_valid && rsp_end_of_image |-> rsp_last_of_run)
   // Nothing follows the final byte of the image.
   `ASSERT_PROP(a_eoi_quiet, clock, reset,
                rsp_valid && rsp_ready && rsp_end_of_image |=> !rsp_valid)

endmodule

`default_nettype wire
